>>> hw/rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types, widths and helpers for the lattice coordinate conversion.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int LAT_W     = 21;   // signed Q8.12 lattice component
    localparam int ROW_W     = 3 * LAT_W;
    localparam int COORD_W   = 32;   // signed Q16.16 coordinate
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 33;   // quotient bits below the overflow check
    localparam int D_W       = 63;   // magnitude of the determinant
    localparam int R_W       = 64;   // divider partial remainder
    localparam int N_W       = 86;   // scaled numerator magnitude
    localparam int SQ_W      = 45;   // quotient width fed to the saturator

    localparam logic [CFG_IDX_W-1:0] REG_ROW_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_C = 2'd2;

    localparam logic [ROW_W-1:0] ROW_A_RST = 63'd4096;
    localparam logic [ROW_W-1:0] ROW_B_RST = 63'd8589934592;
    localparam logic [ROW_W-1:0] ROW_C_RST = 63'd18014398509481984;

    localparam logic ACT_TO_CART = 1'b0;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] coord_a;
        logic signed [COORD_W-1:0] coord_b;
        logic signed [COORD_W-1:0] coord_c;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] result_a;
        logic signed [COORD_W-1:0] result_b;
        logic signed [COORD_W-1:0] result_c;
        logic                      singular;
    } t_out_item;

    // state carried through the restoring divider stages
    typedef struct packed {
        logic [2:0][R_W-1:0]       rem;
        logic [2:0][DIV_STEPS-1:0] quo;
        logic [2:0][DIV_STEPS-1:0] num_lo;
        logic [2:0]                neg;
        logic [2:0]                big;
        logic [D_W-1:0]            dvs;
        logic                      singular;
        logic                      action;
        t_out_item                 fwd;
    } t_div_state;

    // rounded magnitude and sign to a saturated Q16.16 pattern
    function automatic logic [COORD_W-1:0] sat_q16(input logic neg,
                                                   input logic [SQ_W-1:0] q,
                                                   input logic big);
        logic [SQ_W-1:0] nq;
        nq = ~q + 1'b1;
        if (neg) begin
            if (big || q > SQ_W'(64'h8000_0000)) return 32'h8000_0000;
            return nq[COORD_W-1:0];
        end
        if (big || q > SQ_W'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
        return q[COORD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/lcc_div_step.sv
// ----------------------------------------------------------------------------
// lcc_div_step
// One restoring division step for the three inverse channels.
// ----------------------------------------------------------------------------
module lcc_div_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  lcc_pkg::t_div_state i_st,
    output logic                o_vld,
    output lcc_pkg::t_div_state o_st
);
    import lcc_pkg::*;

    logic       r_vld;
    t_div_state r_st;
    t_div_state n_st;
    logic [R_W:0] shifted [3];
    logic [R_W:0] diff    [3];

    always_comb begin
        n_st = i_st;
        for (int k = 0; k < 3; k++) begin
            shifted[k] = {i_st.rem[k], i_st.num_lo[k][DIV_STEPS-1]};
            diff[k]    = shifted[k] - (R_W+1)'(i_st.dvs);
            n_st.num_lo[k] = {i_st.num_lo[k][DIV_STEPS-2:0], 1'b0};
            if (shifted[k] >= (R_W+1)'(i_st.dvs)) begin
                n_st.rem[k] = diff[k][R_W-1:0];
                n_st.quo[k] = {i_st.quo[k][DIV_STEPS-2:0], 1'b1};
            end else begin
                n_st.rem[k] = shifted[k][R_W-1:0];
                n_st.quo[k] = {i_st.quo[k][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

>>> hw/rtl/lattice_coordinate_conversion.sv
// ----------------------------------------------------------------------------
// lattice_coordinate_conversion
// Fractional <-> Cartesian conversion against a configurable 3x3 lattice.
// ----------------------------------------------------------------------------
// One request is taken per clock and one result leaves per clock unless the
// output is stalled. It has six multiply/adjugate stages, 33 restoring divider
// stages for the inverse path, and the output register, which also takes the
// rounded quotient. The whole pipeline holds while a finished result is stalled.
// The user must write lattice rows only while no request is in flight; the
// block itself does not enforce this.
module lattice_coordinate_conversion (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  lcc_pkg::t_in_item                   i_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output lcc_pkg::t_out_item                  o_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lcc_pkg::ROW_W-1:0]           i_cfg_data
);
    import lcc_pkg::*;

    logic [ROW_W-1:0] r_row [3];
    logic             adv;

    logic signed [LAT_W-1:0]   lat [3][3];
    logic signed [COORD_W-1:0] vin [3];

    // stage 1: raw products
    logic                      r_s1_vld, r_s1_act;
    logic signed [COORD_W-1:0] r_s1_v   [3];
    logic signed [41:0]        r_s1_pp  [3][3];
    logic signed [41:0]        r_s1_pm  [3][3];
    logic signed [52:0]        r_s1_fp  [3][3];
    // stage 2: adjugate and forward sums
    logic                      r_s2_vld, r_s2_act;
    logic signed [COORD_W-1:0] r_s2_v   [3];
    logic signed [42:0]        r_s2_adj [3][3];
    logic signed [54:0]        r_s2_fs  [3];
    // stage 3: split products
    logic                      r_s3_vld, r_s3_act;
    logic signed [54:0]        r_s3_lo  [3][3];
    logic signed [52:0]        r_s3_hi  [3][3];
    logic signed [43:0]        r_s3_dlo [3];
    logic signed [41:0]        r_s3_dhi [3];
    t_out_item                 r_s3_fwd;
    // stage 4: numerators and determinant
    logic                      r_s4_vld, r_s4_act;
    logic signed [75:0]        r_s4_acc [3];
    logic signed [64:0]        r_s4_det;
    t_out_item                 r_s4_fwd;
    // stage 5: magnitudes
    logic                      r_s5_vld, r_s5_act, r_s5_sing;
    logic [N_W-1:0]            r_s5_num [3];
    logic [2:0]                r_s5_neg;
    logic [D_W-1:0]            r_s5_d;
    t_out_item                 r_s5_fwd;

    logic       div_vld [DIV_STEPS+1];
    t_div_state div_st  [DIV_STEPS+1];
    t_div_state n_div0;
    logic       r_s6_vld;
    t_div_state r_s6_st;

    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;
    t_out_item n_fwd;

    assign adv         = !r_out_vld || !i_stall;
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_A_RST;
            r_row[1] <= ROW_B_RST;
            r_row[2] <= ROW_C_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW_A: r_row[0] <= i_cfg_data;
                REG_ROW_B: r_row[1] <= i_cfg_data;
                REG_ROW_C: r_row[2] <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign vin[0] = i_item.coord_a;
    assign vin[1] = i_item.coord_b;
    assign vin[2] = i_item.coord_c;

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;
            logic signed [22:0] adj_lo;
            logic signed [20:0] adj_hi;

            assign lat[gi][gj] = r_row[gi][LAT_W*gj +: LAT_W];
            assign adj_lo = {1'b0, r_s2_adj[gi][gj][21:0]};
            assign adj_hi = r_s2_adj[gi][gj][42:22];

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    // adj[i][j] as a cyclic 2x2 minor of the transposed lattice
                    r_s1_pp[gi][gj]  <= lat[J1][I1] * lat[J2][I2];
                    r_s1_pm[gi][gj]  <= lat[J1][I2] * lat[J2][I1];
                    r_s1_fp[gi][gj]  <= vin[gi] * lat[gi][gj];
                    r_s2_adj[gi][gj] <= r_s1_pp[gi][gj] - r_s1_pm[gi][gj];
                    r_s3_lo[gi][gj]  <= r_s2_v[gi] * adj_lo;
                    r_s3_hi[gi][gj]  <= r_s2_v[gi] * adj_hi;
                end
            end
        end

        logic signed [22:0] det_lo;
        logic signed [20:0] det_hi;
        assign det_lo = {1'b0, r_s2_adj[gi][0][21:0]};
        assign det_hi = r_s2_adj[gi][0][42:22];

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s3_dlo[gi] <= lat[0][gi] * det_lo;
                r_s3_dhi[gi] <= lat[0][gi] * det_hi;
            end
        end
    end

    // forward path rounding
    always_comb begin
        logic [54:0] mag;
        logic [55:0] rnd;
        logic [COORD_W-1:0] res [3];
        for (int k = 0; k < 3; k++) begin
            mag    = r_s2_fs[k][54] ? (~r_s2_fs[k] + 1'b1) : r_s2_fs[k];
            rnd    = {1'b0, mag} + 56'd2048;
            res[k] = sat_q16(r_s2_fs[k][54], SQ_W'(rnd[55:12]), 1'b0);
        end
        n_fwd.result_a = res[0];
        n_fwd.result_b = res[1];
        n_fwd.result_c = res[2];
        n_fwd.singular = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_act <= i_item.action;
            r_s1_v   <= vin;
            r_s2_act <= r_s1_act;
            r_s2_v   <= r_s1_v;
            for (int k = 0; k < 3; k++) begin
                r_s2_fs[k] <= 55'(r_s1_fp[0][k]) + 55'(r_s1_fp[1][k]) + 55'(r_s1_fp[2][k]);
            end
            r_s3_act <= r_s2_act;
            r_s3_fwd <= n_fwd;
            r_s4_act <= r_s3_act;
            r_s4_fwd <= r_s3_fwd;
            for (int k = 0; k < 3; k++) begin
                r_s4_acc[k] <= (76'(r_s3_hi[0][k]) <<< 22) + 76'(r_s3_lo[0][k])
                             + (76'(r_s3_hi[1][k]) <<< 22) + 76'(r_s3_lo[1][k])
                             + (76'(r_s3_hi[2][k]) <<< 22) + 76'(r_s3_lo[2][k]);
            end
            r_s4_det <= (65'(r_s3_dhi[0]) <<< 22) + 65'(r_s3_dlo[0])
                      + (65'(r_s3_dhi[1]) <<< 22) + 65'(r_s3_dlo[1])
                      + (65'(r_s3_dhi[2]) <<< 22) + 65'(r_s3_dlo[2]);
            r_s5_act  <= r_s4_act;
            r_s5_fwd  <= r_s4_fwd;
            r_s5_sing <= (r_s4_det == '0);
            for (int k = 0; k < 3; k++) begin
                r_s5_num[k] <= {r_s4_acc[k][75] ? 74'(~r_s4_acc[k] + 1'b1)
                                                : 74'(r_s4_acc[k]), 12'd0};
                r_s5_neg[k] <= r_s4_acc[k][75] ^ r_s4_det[64];
            end
            r_s5_d <= r_s4_det[64] ? D_W'(~r_s4_det + 1'b1) : D_W'(r_s4_det);
            r_s6_st <= n_div0;
        end
    end

    // quotient overflow check and divider seed
    always_comb begin
        n_div0          = '0;
        n_div0.dvs      = r_s5_d;
        n_div0.singular = r_s5_sing;
        n_div0.action   = r_s5_act;
        n_div0.fwd      = r_s5_fwd;
        n_div0.neg      = r_s5_neg;
        for (int k = 0; k < 3; k++) begin
            n_div0.big[k]    = (R_W'(r_s5_num[k][N_W-1:DIV_STEPS]) >= R_W'(r_s5_d));
            n_div0.rem[k]    = R_W'(r_s5_num[k][N_W-1:DIV_STEPS]);
            n_div0.num_lo[k] = r_s5_num[k][DIV_STEPS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= i_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_out_vld <= div_vld[DIV_STEPS];
        end
    end

    assign div_vld[0] = r_s6_vld;
    assign div_st[0]  = r_s6_st;

    for (genvar gs = 0; gs < DIV_STEPS; gs++) begin : g_div
        lcc_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_vld   (div_vld[gs]),
            .i_st    (div_st[gs]),
            .o_vld   (div_vld[gs+1]),
            .o_st    (div_st[gs+1])
        );
    end

    // final rounding of the quotient, ties away from zero
    always_comb begin
        t_div_state         fin;
        logic [R_W:0]       rem2;
        logic [SQ_W-1:0]    q;
        logic [COORD_W-1:0] res [3];
        fin = div_st[DIV_STEPS];
        for (int k = 0; k < 3; k++) begin
            rem2   = {fin.rem[k], 1'b0};
            q      = SQ_W'(fin.quo[k]) + SQ_W'(rem2 >= (R_W+1)'(fin.dvs));
            res[k] = sat_q16(fin.neg[k], q, fin.big[k]);
        end
        if (fin.action == ACT_TO_CART) begin
            n_out = fin.fwd;
        end else if (fin.singular) begin
            n_out          = '0;
            n_out.singular = 1'b1;
        end else begin
            n_out.result_a = res[0];
            n_out.result_b = res[1];
            n_out.result_c = res[2];
            n_out.singular = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.singular) |-> (o_item.result_a == '0 && o_item.result_b == '0
                                          && o_item.result_c == '0))
        else $error("singular result with nonzero coordinates");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_vld)
        else $error("accepted request missing from first stage");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_s6_vld) && $stable(div_vld[DIV_STEPS])))
        else $error("pipeline moved while result stalled");

endmodule
